FILE: hdl/assert_macros.svh
// assertion macros used by the checker lru_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define LRU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru replacement policy check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define LRU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru replacement policy check failed");

`endif

FILE: hdl/lru_pkg.sv
// shared types and constants of the lru replacement policy
`default_nettype none

package lru_pkg;

  localparam int OP_W  = 2;
  localparam int SET_W = 10;
  localparam int WAY_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH = 2'd0,
    OP_ALLOC = 2'd1,
    OP_INVAL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic pick;
    logic update;
    logic respond;
  } lru_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } lru_status_t;

endpackage

`default_nettype wire

FILE: hdl/lru_ctrl.sv
// controller state machine: clearing pass, then read, pick, update, write-back per request
`default_nettype none

module lru_ctrl
  import lru_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lru_status_t status,
  output lru_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ:   state_next = ST_PICK;
      ST_PICK:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_RESP;
      ST_RESP: begin
        // hold the result until the output register can take it
        if (status.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_READ:   cmd.read = 1'b1;
      ST_PICK:   cmd.pick = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_RESP:   cmd.respond = status.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/lru_dp.sv
// datapath: per-set row memory, way selection, age promotion and output register
`default_nettype none

module lru_dp
  import lru_pkg::*;
#(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  lru_cmd_t         cmd,
  output lru_status_t      status,
  input  logic [OP_W-1:0]  operation,
  input  logic [SET_W-1:0] set_index,
  input  logic [WAY_W-1:0] way,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WAY_W-1:0] chosen_way,
  output logic             filled_invalid
);

  localparam int AGE_W   = $clog2(NUM_WAYS);
  localparam int AGES_W  = NUM_WAYS * AGE_W;
  localparam int ROW_W   = AGES_W + NUM_WAYS;
  localparam int ADDR_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int EXT_W   = (ADDR_W > SET_W) ? ADDR_W : SET_W;
  localparam int WEXT_W  = (AGE_W > WAY_W) ? AGE_W : WAY_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SETS - 1);
  localparam logic [AGE_W-1:0]  TOP_AGE   = AGE_W'(NUM_WAYS - 1);

  // row layout: ages of way k at [k*AGE_W +: AGE_W], valid bits on top
  logic [ROW_W-1:0] mem [NUM_SETS];

  op_t              req_op;
  logic [SET_W-1:0] req_set;
  logic [WAY_W-1:0] req_way;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] new_row;
  logic [ROW_W-1:0] new_row_next;
  logic [ROW_W-1:0] reset_row;
  logic [ADDR_W-1:0] clr_addr;

  logic [AGE_W-1:0] tgt;
  logic             do_prom;
  logic             set_vld;
  logic             clr_vld;
  logic [WAY_W-1:0] res_way;
  logic             res_filled;

  logic [EXT_W-1:0]  set_ext;
  logic [ADDR_W-1:0] mem_addr;
  logic              set_ok;
  logic [WEXT_W-1:0] way_ext;
  logic [AGE_W-1:0]  way_idx;
  logic              way_ok;

  logic [AGE_W-1:0]    age [NUM_WAYS];
  logic [NUM_WAYS-1:0] valid;
  logic [AGE_W-1:0]    inv_best;
  logic [AGE_W-1:0]    inv_age;
  logic                inv_found;
  logic [AGE_W-1:0]    lru_way;

  assign set_ext  = EXT_W'(req_set);
  assign mem_addr = set_ext[ADDR_W-1:0];
  assign set_ok   = (32'(req_set) < 32'(NUM_SETS));
  assign way_ext  = WEXT_W'(req_way);
  assign way_idx  = way_ext[AGE_W-1:0];
  assign way_ok   = (32'(req_way) < 32'(NUM_WAYS));

  always_comb begin
    reset_row = '0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      reset_row[k*AGE_W +: AGE_W] = AGE_W'(k);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_WAYS; k++) begin
      age[k] = row[k*AGE_W +: AGE_W];
    end
    valid = row[ROW_W-1 -: NUM_WAYS];
  end

  // invalid way with the smallest age, and the way holding age zero
  always_comb begin
    inv_found = 1'b0;
    inv_best  = '0;
    inv_age   = '0;
    lru_way   = '0;
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (!valid[k] && (!inv_found || age[k] < inv_age)) begin
        inv_found = 1'b1;
        inv_best  = AGE_W'(k);
        inv_age   = age[k];
      end
    end
    for (int k = NUM_WAYS - 1; k >= 0; k--) begin
      if (age[k] == '0) lru_way = AGE_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= op_t'(operation);
      req_set <= set_index;
      req_way <= way;
    end
    if (cmd.read) begin
      row <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      unique case (req_op)
        OP_ALLOC: begin
          tgt        <= inv_found ? inv_best : lru_way;
          do_prom    <= set_ok;
          set_vld    <= set_ok;
          clr_vld    <= 1'b0;
          res_way    <= set_ok ? WAY_W'(inv_found ? inv_best : lru_way) : '0;
          res_filled <= set_ok && inv_found;
        end
        OP_TOUCH: begin
          tgt        <= way_idx;
          do_prom    <= set_ok && way_ok;
          set_vld    <= 1'b0;
          clr_vld    <= 1'b0;
          res_way    <= req_way;
          res_filled <= 1'b0;
        end
        OP_INVAL: begin
          tgt        <= way_idx;
          do_prom    <= 1'b0;
          set_vld    <= 1'b0;
          clr_vld    <= set_ok && way_ok;
          res_way    <= req_way;
          res_filled <= 1'b0;
        end
        default: begin
          tgt        <= way_idx;
          do_prom    <= 1'b0;
          set_vld    <= 1'b0;
          clr_vld    <= 1'b0;
          res_way    <= req_way;
          res_filled <= 1'b0;
        end
      endcase
    end
  end

  // promote: ages above the target's drop by one, the target takes the top age
  always_comb begin
    logic [AGE_W-1:0]    mine;
    logic [NUM_WAYS-1:0] v;
    mine = age[tgt];
    v    = valid;
    new_row_next = row;
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (do_prom) begin
        if (AGE_W'(k) == tgt) begin
          new_row_next[k*AGE_W +: AGE_W] = TOP_AGE;
        end else if (age[k] > mine) begin
          new_row_next[k*AGE_W +: AGE_W] = age[k] - AGE_W'(1);
        end
      end
    end
    if (set_vld) v[tgt] = 1'b1;
    if (clr_vld) v[tgt] = 1'b0;
    new_row_next[ROW_W-1 -: NUM_WAYS] = v;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      new_row <= new_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr] <= reset_row;
    end else if (cmd.respond && set_ok) begin
      mem[mem_addr] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      chosen_way     <= res_way;
      filled_invalid <= res_filled;
    end
  end

  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

FILE: hdl/lru_way_replacement_policy.sv
// Counter-based true-LRU replacement policy for one set-associative cache. Each set keeps
// one age per way (age 0 is least recent) and one valid bit per way, stored together as one
// row of a single-port memory of NUM_SETS rows. Operation 0 touches a way, 1 allocates a way
// (oldest invalid way first, else the way of age 0) and returns it, 2 invalidates a way.
// After reset a clearing pass loads every row with its reset ages; in_stall stays high
// during that pass. Each accepted request then goes through row read, way pick, age update
// and write-back with the output register load; only read and write-back use the memory
// port; write-back waits for a free output register. A request is not taken until the one
// before it is written back, yet is accepted while an earlier result waits on out_stall.
`default_nettype none

module lru_way_replacement_policy
  import lru_pkg::*;
#(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  operation,
  input  logic [SET_W-1:0] set_index,
  input  logic [WAY_W-1:0] way,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WAY_W-1:0] chosen_way,
  output logic             filled_invalid
);

  lru_cmd_t    cmd;
  lru_status_t status;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lru_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .set_index      (set_index),
    .way            (way),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .chosen_way     (chosen_way),
    .filled_invalid (filled_invalid)
  );

endmodule

`default_nettype wire

FILE: hdl/lru_chk.sv
// port-level checker for the lru replacement policy, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module lru_chk
  import lru_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [OP_W-1:0]  operation,
  input logic [WAY_W-1:0] way,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WAY_W-1:0] chosen_way,
  input logic             filled_invalid
);

  // requests accepted but not yet delivered, oldest first
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;
  logic [1:0]      idx;
  logic [OP_W-1:0] q_op  [2];
  logic [WAY_W-1:0] q_way [2];
  logic            push;
  logic            pop;

  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;
  assign idx  = pop ? cnt - 2'd1 : cnt;

  always_comb begin
    cnt_next = cnt;
    priority if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && idx == 2'd0) begin
      q_op[0]  <= operation;
      q_way[0] <= way;
    end else if (pop) begin
      q_op[0]  <= q_op[1];
      q_way[0] <= q_way[1];
    end
    if (push && idx == 2'd1) begin
      q_op[1]  <= operation;
      q_way[1] <= way;
    end
  end

  `LRU_ASSERT_IMPL(a_no_spurious_result, out_valid, cnt != 2'd0)
  `LRU_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(chosen_way) && $stable(filled_invalid))
  `LRU_ASSERT_IMPL(a_echo_non_alloc, out_valid && q_op[0] != OP_ALLOC, chosen_way == q_way[0] && !filled_invalid)
  `LRU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind lru_way_replacement_policy lru_chk u_lru_chk (.*);

`default_nettype wire
